// ===== design/i2cm_pkg.sv =====
// ----------------------------------------------------------------------------
// i2cm_pkg
// Shared types and constants for the I2C master bit engine.
// ----------------------------------------------------------------------------
package i2cm_pkg;

	localparam int unsigned OpW      = 3;
	localparam int unsigned ByteW    = 8;
	localparam int unsigned HalfW    = 16;
	localparam int unsigned IdxW     = 4;
	localparam int unsigned BitsLast = 9;

	localparam logic [OpW-1:0] OP_NONE  = 3'd0;
	localparam logic [OpW-1:0] OP_START = 3'd1;
	localparam logic [OpW-1:0] OP_STOP  = 3'd2;
	localparam logic [OpW-1:0] OP_WRITE = 3'd3;
	localparam logic [OpW-1:0] OP_READ  = 3'd4;

	localparam logic [HalfW-1:0] HALF_RESET = 16'd5;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_START = 5'b00010,
		ST_STOP  = 5'b00100,
		ST_WRITE = 5'b01000,
		ST_READ  = 5'b10000
	} cmd_state_t;

	typedef struct packed {
		logic [OpW-1:0]   opcode;
		logic [ByteW-1:0] data_byte;
		logic             send_ack;
		logic             sda_in;
	} req_t;

	typedef struct packed {
		logic             ack_seen;
		logic [ByteW-1:0] read_data;
		logic             done_res;
		logic             busy_res;
		logic             sda_out;
		logic             scl_out;
	} res_t;

endpackage

// ===== design/i2cm_seq.sv =====
// ----------------------------------------------------------------------------
// i2cm_seq
// Line sequencer state: advances one tick per accepted request and forms
// the line levels and status for that tick.
// ----------------------------------------------------------------------------
module i2cm_seq import i2cm_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [HalfW-1:0] cfg_wdata,
	input  logic             step,
	input  req_t             req,
	output res_t             res
);

	logic [HalfW-1:0] half_q;
	cmd_state_t       state_q, state_n;
	logic [1:0]       phase_q, phase_n;
	logic [IdxW-1:0]  idx_q, idx_n;
	logic [ByteW-1:0] shift_q, shift_n;
	logic [HalfW-1:0] wait_q, wait_n;
	logic             scl_q, scl_n;
	logic             sda_q, sda_n;
	logic             ack_q, ack_n;
	logic             pend_q, pend_n;
	logic [ByteW-1:0] rdata_q, rdata_n;
	logic             done;
	logic [HalfW-1:0] load_val;
	logic [IdxW-1:0]  idx_inc;

	assign load_val = (half_q == '0) ? HalfW'(1) : half_q;
	assign idx_inc  = idx_q + IdxW'(1);

	always_comb begin
		state_n = state_q;
		phase_n = phase_q;
		idx_n   = idx_q;
		shift_n = shift_q;
		wait_n  = wait_q;
		scl_n   = scl_q;
		sda_n   = sda_q;
		ack_n   = ack_q;
		pend_n  = pend_q;
		rdata_n = rdata_q;
		done    = 1'b0;
		if (state_q == ST_IDLE) begin
			case (req.opcode)
				OP_START: begin
					phase_n = 2'd1;
					idx_n   = '0;
					scl_n   = 1'b1;
					sda_n   = 1'b1;
					state_n = ST_START;
					wait_n  = load_val;
				end
				OP_STOP: begin
					phase_n = 2'd1;
					idx_n   = '0;
					sda_n   = 1'b0;
					state_n = ST_STOP;
					wait_n  = load_val;
				end
				OP_WRITE: begin
					phase_n = 2'd1;
					idx_n   = '0;
					shift_n = req.data_byte;
					sda_n   = req.data_byte[ByteW-1];
					state_n = ST_WRITE;
					wait_n  = load_val;
				end
				OP_READ: begin
					phase_n = 2'd1;
					idx_n   = '0;
					pend_n  = req.send_ack;
					shift_n = '0;
					sda_n   = 1'b1;
					state_n = ST_READ;
					wait_n  = load_val;
				end
				default: begin
				end
			endcase
		end else if (wait_q > HalfW'(1)) begin
			wait_n = wait_q - HalfW'(1);
		end else if (phase_q == 2'd1) begin
			if (state_q == ST_START)
				sda_n = 1'b0;
			else
				scl_n = 1'b1;
			phase_n = 2'd2;
			wait_n  = load_val;
		end else begin
			unique case (state_q)
				ST_START: begin
					scl_n = 1'b0;
					done  = 1'b1;
				end
				ST_STOP: begin
					sda_n = 1'b1;
					done  = 1'b1;
				end
				ST_WRITE, ST_READ: begin
					if (state_q == ST_WRITE) begin
						if (idx_q >= IdxW'(ByteW))
							ack_n = ~req.sda_in;
						else
							shift_n = {shift_q[ByteW-2:0], 1'b0};
					end else if (idx_q < IdxW'(ByteW)) begin
						shift_n = {shift_q[ByteW-2:0], req.sda_in};
					end
					scl_n = 1'b0;
					idx_n = idx_inc;
					if (idx_inc >= IdxW'(BitsLast)) begin
						if (state_q == ST_READ)
							rdata_n = shift_n;
						done = 1'b1;
					end else begin
						if (state_q == ST_WRITE)
							sda_n = (idx_inc < IdxW'(ByteW)) ? shift_n[ByteW-1] : 1'b1;
						else
							sda_n = (idx_inc < IdxW'(ByteW)) ? 1'b1 : ~pend_q;
						phase_n = 2'd1;
						wait_n  = load_val;
					end
				end
				default: done = 1'b1;
			endcase
			if (done) begin
				state_n = ST_IDLE;
				phase_n = 2'd0;
				wait_n  = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_q <= HALF_RESET;
		end else if (cfg_we) begin
			half_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			phase_q <= 2'd0;
			idx_q   <= '0;
			shift_q <= '0;
			wait_q  <= '0;
			scl_q   <= 1'b1;
			sda_q   <= 1'b1;
			ack_q   <= 1'b0;
			pend_q  <= 1'b0;
			rdata_q <= '0;
		end else if (step) begin
			state_q <= state_n;
			phase_q <= phase_n;
			idx_q   <= idx_n;
			shift_q <= shift_n;
			wait_q  <= wait_n;
			scl_q   <= scl_n;
			sda_q   <= sda_n;
			ack_q   <= ack_n;
			pend_q  <= pend_n;
			rdata_q <= rdata_n;
		end
	end

	assign res.scl_out   = scl_n;
	assign res.sda_out   = sda_n;
	assign res.busy_res  = (state_n != ST_IDLE);
	assign res.done_res  = done;
	assign res.read_data = rdata_n;
	assign res.ack_seen  = ack_n;

	a_idle_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (phase_q == 2'd0 && wait_q == '0))
		else $error("idle with live phase or delay");

	a_busy_wait: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> (wait_q != '0 && phase_q != 2'd0))
		else $error("command in progress without a delay loaded");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(step && res.done_res) |=> (state_q == ST_IDLE))
		else $error("completion did not return to idle");

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= IdxW'(BitsLast))
		else $error("bit index out of range");

endmodule

// ===== design/i2cm_out_reg.sv =====
// ----------------------------------------------------------------------------
// i2cm_out_reg
// Result register: holds one result until taken and accepts the next
// request in the cycle the held result leaves.
// ----------------------------------------------------------------------------
module i2cm_out_reg import i2cm_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic load,
	input  res_t res_in,
	input  logic take,
	output logic ready,
	output logic valid,
	output res_t res_out
);

	logic valid_q;

	assign ready = !valid_q || take;
	assign valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (take) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_out <= res_in;
		end
	end

endmodule

// ===== design/i2c_master_bit_engine_core.sv =====
// Output: a result is registered and appears in the cycle after its request is accepted.
// Throughput: one request per cycle; the sequencer next-state logic and the
// result register together sustain a tick every clock while results are taken.
// Reset: lines released high, sequencer idle, half period 5, no result held.
// ----------------------------------------------------------------------------
// i2c_master_bit_engine_core
// I2C master bit engine: start, stop, write byte and read byte sequencing,
// one tick per request.
// ----------------------------------------------------------------------------
module i2c_master_bit_engine_core import i2cm_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [HalfW-1:0] cfg_wdata,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [15:0]      s_tdata,  // data_byte[7:0], send_ack[8], sda_in[9], zeros
	input  logic [OpW-1:0]   s_tuser,  // opcode[2:0]
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [15:0]      m_tdata   // scl_out, sda_out, busy_res, done_res,
	                                   // read_data[11:4], ack_seen[12], zeros
);

	req_t req;
	res_t res_next;
	res_t res_held;
	logic step;

	assign req.opcode    = s_tuser;
	assign req.data_byte = s_tdata[7:0];
	assign req.send_ack  = s_tdata[8];
	assign req.sda_in    = s_tdata[9];

	assign step = s_tvalid && s_tready;

	i2cm_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.step      (step),
		.req       (req),
		.res       (res_next)
	);

	i2cm_out_reg u_out (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (step),
		.res_in  (res_next),
		.take    (m_tready),
		.ready   (s_tready),
		.valid   (m_tvalid),
		.res_out (res_held)
	);

	assign m_tdata = {3'b000, res_held.ack_seen, res_held.read_data, res_held.done_res,
		res_held.busy_res, res_held.sda_out, res_held.scl_out};

endmodule
